### hdl/strength_reduction_classifier_unit_defines.svh
// assertion macros for the strength reduction classifier
`ifndef STRENGTH_REDUCTION_CLASSIFIER_UNIT_DEFINES_SVH
`define STRENGTH_REDUCTION_CLASSIFIER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SRC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define SRC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### hdl/src_pkg.sv
// ----------------------------------------------------------------------------
// src_pkg
// shared types and constants of the strength reduction classifier
// ----------------------------------------------------------------------------
package src_pkg;

    localparam int DATA_W = 64;
    localparam int PREC_LIMIT = 128;
    localparam int PREC_START = 63;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1,
        OP_REM = 2'd2,
        OP_OTHER = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        RK_NONE = 4'd0,
        RK_MUL_SHL = 4'd1,
        RK_SHL_ADD = 4'd2,
        RK_SHL_SUB = 4'd3,
        RK_UDIV_SHR = 4'd4,
        RK_UREM_AND = 4'd5,
        RK_SDIV_POW2 = 4'd6,
        RK_SREM_POW2 = 4'd7,
        RK_DIV_MAGIC = 4'd8,
        RK_REM_MAGIC = 4'd9
    } t_kind;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_LOAD = 3'd1,
        CMD_DIV_STEP = 3'd2,
        CMD_SETUP_B = 3'd3,
        CMD_SETUP_C = 3'd4,
        CMD_SETUP_D = 3'd5,
        CMD_LOOP = 3'd6,
        CMD_FINISH = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
    } t_ctrl;

    typedef struct packed {
        logic magic;
        logic div_last;
        logic loop_done;
    } t_stat;

    function automatic logic is_pow2(input logic [DATA_W-1:0] v);
        return (v != '0) && ((v & (v - 64'd1)) == '0);
    endfunction

    function automatic logic [6:0] log2_of(input logic [DATA_W-1:0] v);
        logic [6:0] e;
        e = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (v[i]) e = 7'(i);
        end
        return e;
    endfunction

endpackage

### hdl/src_datapath.sv
// ----------------------------------------------------------------------------
// src_datapath
// rule table, shared restoring divider and magic refinement loop
// ----------------------------------------------------------------------------
module src_datapath
    import src_pkg::*;
(
    input  logic              i_clk,
    input  t_ctrl             i_ctrl,
    input  logic [1:0]        i_op_kind,
    input  logic [DATA_W-1:0] i_constant_value,
    input  logic              i_operand_unsigned,
    output t_stat             o_stat,
    output logic              o_matched,
    output logic [3:0]        o_rewrite_kind,
    output logic [6:0]        o_shift_amount,
    output logic [62:0]       o_mask_value,
    output logic [63:0]       o_magic_multiplier,
    output logic              o_magic_add_flag
);

    logic [63:0] r_dmag, r_nc, r_qa, r_ra, r_qb, r_rb;
    logic        r_uns, r_neg, r_add, r_magic;
    logic [3:0]  r_kind;
    logic [6:0]  r_k;
    logic [7:0]  r_prec;
    logic [62:0] r_mask;
    logic        r_match;
    logic [1:0]  r_phase;
    // divider
    logic [63:0] r_dv_n, r_dv_d, r_dv_q, r_dv_r;
    logic [6:0]  r_dv_cnt;

    logic [64:0] dv_tr;
    logic [63:0] dv_rs;
    logic        dv_ge;
    logic [63:0] gap;
    logic        cont;

    assign dv_rs = {r_dv_r[62:0], r_dv_n[63]};
    assign dv_tr = {r_dv_r, r_dv_n[63]} - {1'b0, r_dv_d};
    assign dv_ge = !dv_tr[64];

    assign gap = r_uns ? (r_dmag - 64'd1 - r_rb) : (r_dmag - r_rb);
    assign cont = (r_prec < 8'(PREC_LIMIT))
        && ((r_qa < gap) || ((r_qa == gap) && (r_ra == '0)));

    assign o_stat.magic = r_magic;
    assign o_stat.div_last = (r_dv_cnt == 7'd64);
    assign o_stat.loop_done = !cont;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            CMD_LOAD: begin : ld
                logic [63:0] c;
                logic sneg, gt1, gt2, uns, gen;
                logic [3:0] kd;
                logic [6:0] k;
                logic [62:0] mk;
                logic mg;
                c = i_constant_value;
                uns = i_operand_unsigned;
                sneg = c[63];
                gt1 = !sneg && (c > 64'd1);
                gt2 = !sneg && (c > 64'd2);
                gen = (c != 64'd0) && (c != 64'd1) && (c != '1);
                kd = RK_NONE; k = '0; mk = '0; mg = 1'b0;
                if (!(uns && sneg)) begin
                    case (i_op_kind)
                        OP_MUL: begin
                            if (gt1 && is_pow2(c)) begin
                                kd = RK_MUL_SHL; k = log2_of(c);
                            end else if (gt2 && is_pow2(c - 64'd1)
                                    && log2_of(c - 64'd1) >= 7'd2) begin
                                kd = RK_SHL_ADD; k = log2_of(c - 64'd1);
                            end else if (gt2 && is_pow2(c + 64'd1)
                                    && log2_of(c + 64'd1) >= 7'd2) begin
                                kd = RK_SHL_SUB; k = log2_of(c + 64'd1);
                            end
                        end
                        OP_DIV, OP_REM: begin
                            if (gt1 && is_pow2(c)) begin
                                k = log2_of(c);
                                if (i_op_kind == OP_DIV) begin
                                    kd = uns ? RK_UDIV_SHR : RK_SDIV_POW2;
                                end else begin
                                    kd = uns ? RK_UREM_AND : RK_SREM_POW2;
                                    mk = c[62:0] - 63'd1;
                                end
                            end else if (gen) begin
                                kd = (i_op_kind == OP_DIV) ? RK_DIV_MAGIC : RK_REM_MAGIC;
                                mg = 1'b1;
                            end
                        end
                        default: kd = RK_NONE;
                    endcase
                end
                r_uns <= uns; r_neg <= sneg;
                r_kind <= kd; r_k <= k; r_mask <= mk; r_magic <= mg;
                r_match <= (kd != RK_NONE);
                r_dmag <= sneg ? (64'd0 - c) : c;
                r_add <= 1'b0;
                r_phase <= 2'd0;
                // first division: t % dmag (signed) or (-d) % d (unsigned)
                r_dv_n <= uns ? (64'd0 - c) : (64'h8000000000000000 | {63'd0, sneg});
                r_dv_d <= sneg ? (64'd0 - c) : c;
                r_dv_q <= '0; r_dv_r <= '0; r_dv_cnt <= '0;
            end
            CMD_DIV_STEP: begin
                r_dv_r <= dv_ge ? dv_tr[63:0] : dv_rs;
                r_dv_q <= {r_dv_q[62:0], dv_ge};
                r_dv_n <= {r_dv_n[62:0], 1'b0};
                r_dv_cnt <= r_dv_cnt + 7'd1;
            end
            CMD_SETUP_B: begin
                // nc from remainder, then divide 2^63 by nc
                if (r_uns) begin
                    r_nc <= '1 - r_dv_r;
                    r_dv_d <= '1 - r_dv_r;
                end else begin
                    r_nc <= (64'h8000000000000000 | {63'd0, r_neg}) - 64'd1 - r_dv_r;
                    r_dv_d <= (64'h8000000000000000 | {63'd0, r_neg}) - 64'd1 - r_dv_r;
                end
                r_dv_n <= 64'h8000000000000000;
                r_dv_q <= '0; r_dv_r <= '0; r_dv_cnt <= '0;
            end
            CMD_SETUP_C: begin
                r_qa <= r_dv_q; r_ra <= r_dv_r;
                r_dv_n <= r_uns ? 64'h7fffffffffffffff : 64'h8000000000000000;
                r_dv_d <= r_dmag;
                r_dv_q <= '0; r_dv_r <= '0; r_dv_cnt <= '0;
            end
            CMD_SETUP_D: begin
                r_qb <= r_dv_q; r_rb <= r_dv_r;
                r_prec <= 8'(PREC_START);
            end
            CMD_LOOP: begin
                r_prec <= r_prec + 8'd1;
                if (r_uns) begin
                    if (r_ra >= r_nc - r_ra) begin
                        r_qa <= {r_qa[62:0], 1'b1}; r_ra <= {r_ra[62:0], 1'b0} - r_nc;
                    end else begin
                        r_qa <= {r_qa[62:0], 1'b0}; r_ra <= {r_ra[62:0], 1'b0};
                    end
                    if (r_rb + 64'd1 >= r_dmag - r_rb) begin
                        if (r_qb >= 64'h7fffffffffffffff) r_add <= 1'b1;
                        r_qb <= {r_qb[62:0], 1'b1};
                        r_rb <= {r_rb[62:0], 1'b1} - r_dmag;
                    end else begin
                        if (r_qb >= 64'h8000000000000000) r_add <= 1'b1;
                        r_qb <= {r_qb[62:0], 1'b0};
                        r_rb <= {r_rb[62:0], 1'b1};
                    end
                end else begin
                    if ({r_ra[62:0], 1'b0} >= r_nc) begin
                        r_qa <= {r_qa[62:0], 1'b1}; r_ra <= {r_ra[62:0], 1'b0} - r_nc;
                    end else begin
                        r_qa <= {r_qa[62:0], 1'b0}; r_ra <= {r_ra[62:0], 1'b0};
                    end
                    if ({r_rb[62:0], 1'b0} >= r_dmag) begin
                        r_qb <= {r_qb[62:0], 1'b1}; r_rb <= {r_rb[62:0], 1'b0} - r_dmag;
                    end else begin
                        r_qb <= {r_qb[62:0], 1'b0}; r_rb <= {r_rb[62:0], 1'b0};
                    end
                end
            end
            CMD_FINISH: begin
                r_qb <= (r_neg && !r_uns) ? (64'd0 - (r_qb + 64'd1)) : (r_qb + 64'd1);
                r_k <= 7'(r_prec - 8'd64);
                r_phase <= 2'd1;
            end
            default: r_phase <= r_phase;
        endcase
    end

    assign o_matched = r_match;
    assign o_rewrite_kind = r_kind;
    assign o_shift_amount = r_k;
    assign o_mask_value = r_mask;
    assign o_magic_multiplier = (r_magic && r_phase == 2'd1) ? r_qb : '0;
    assign o_magic_add_flag = r_magic && r_uns && r_add;

endmodule

### hdl/src_ctrl.sv
// ----------------------------------------------------------------------------
// src_ctrl
// sequencer for the classifier datapath and the handshakes
// ----------------------------------------------------------------------------
module src_ctrl
    import src_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_DIV_A, S_DIV_B, S_DIV_C, S_LOOP, S_OUT
    } t_state;

    t_state r_state;
    logic   r_valid;
    // the loop body runs at least once
    logic   r_first;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_ctrl.cmd = CMD_NONE;
        case (r_state)
            S_IDLE: if (i_valid) o_ctrl.cmd = CMD_LOAD;
            S_DIV_A: o_ctrl.cmd = i_stat.div_last ? CMD_SETUP_B : CMD_DIV_STEP;
            S_DIV_B: o_ctrl.cmd = i_stat.div_last ? CMD_SETUP_C : CMD_DIV_STEP;
            S_DIV_C: o_ctrl.cmd = i_stat.div_last ? CMD_SETUP_D : CMD_DIV_STEP;
            S_LOOP: o_ctrl.cmd = (i_stat.loop_done && !r_first) ? CMD_FINISH : CMD_LOOP;
            default: o_ctrl.cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_first <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) r_state <= S_CHECK;
                S_CHECK: begin
                    if (i_stat.magic) begin
                        r_state <= S_DIV_A;
                    end else begin
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end
                end
                S_DIV_A: if (i_stat.div_last) r_state <= S_DIV_B;
                S_DIV_B: if (i_stat.div_last) r_state <= S_DIV_C;
                S_DIV_C: if (i_stat.div_last) begin
                    r_state <= S_LOOP;
                    r_first <= 1'b1;
                end
                S_LOOP: begin
                    r_first <= 1'b0;
                    if (i_stat.loop_done && !r_first) begin
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end
                end
                S_OUT: if (i_ready) begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/strength_reduction_classifier_unit.sv
// ----------------------------------------------------------------------------
// strength_reduction_classifier_unit
// classifies x op C and returns the rewrite, with magic division constants
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | i_valid / o_ready
// out     | output    | o_valid / i_ready
// non-magic items: after accept the sequencer passes the check state, then raises valid
// magic items run three 64-bit divisions one after another on one shared divider,
// each followed by a setup step, then the refinement loop of at least one step
// (bounded by the precision limit) and a finish step before valid is raised
// one transaction in flight; ready is low until the result is taken
// synchronous active-low reset returns the sequencer to idle
// ----------------------------------------------------------------------------
`include "strength_reduction_classifier_unit_defines.svh"

module strength_reduction_classifier_unit
    import src_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op_kind,
    input  logic [63:0] i_constant_value,
    input  logic        i_operand_unsigned,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_matched,
    output logic [3:0]  o_rewrite_kind,
    output logic [6:0]  o_shift_amount,
    output logic [62:0] o_mask_value,
    output logic [63:0] o_magic_multiplier,
    output logic        o_magic_add_flag
);

    t_ctrl ctrl;
    t_stat stat;

    src_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_stat(stat), .o_ctrl(ctrl)
    );

    src_datapath u_dp (
        .i_clk(i_clk), .i_ctrl(ctrl), .i_op_kind(i_op_kind),
        .i_constant_value(i_constant_value), .i_operand_unsigned(i_operand_unsigned),
        .o_stat(stat), .o_matched(o_matched), .o_rewrite_kind(o_rewrite_kind),
        .o_shift_amount(o_shift_amount), .o_mask_value(o_mask_value),
        .o_magic_multiplier(o_magic_multiplier), .o_magic_add_flag(o_magic_add_flag)
    );

    `SRC_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, o_valid, !o_ready)
    `SRC_ASSERT_IMP(a_nomatch_zero, i_clk, i_rst_n, o_valid && !o_matched,
        o_rewrite_kind == RK_NONE && o_magic_multiplier == '0)
    `SRC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready && !o_valid)

endmodule
